[src/gbi_pkg.sv]
// ----------------------------------------------------------------------------
// gbi_pkg: shared types and constants of the grid bilinear interpolator
// Item structs, register indexes, mode codes and size defaults.
// ----------------------------------------------------------------------------
package gbi_pkg;

  // Default storage sizes.
  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int COMPONENTS_DEF = 4;

  // Fixed field widths.
  localparam int SAMPLE_W = 32;
  localparam int OFF_W    = 17;

  // Offset of one whole cell in Q1.16.
  localparam logic [OFF_W-1:0] OFF_ONE = 17'd65536;

  // Register reset values.
  localparam logic [31:0] INV_SPACING_RST = 32'd65536;
  localparam logic [8:0]  CELLS_USED_RST  = 9'd256;

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ORIGIN_X1      = 3'd0,
    CFG_ORIGIN_X2      = 3'd1,
    CFG_INV_SPACING_X1 = 3'd2,
    CFG_INV_SPACING_X2 = 3'd3,
    CFG_CELLS_USED_X1  = 3'd4,
    CFG_CELLS_USED_X2  = 3'd5
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    logic               mode;
    logic        [7:0]  cell_row;
    logic        [7:0]  cell_col;
    logic signed [31:0] sample_c0;
    logic signed [31:0] sample_c1;
    logic signed [31:0] sample_c2;
    logic signed [31:0] sample_c3;
    logic signed [31:0] point_x1;
    logic signed [31:0] point_x2;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] blend_c0;
    logic signed [31:0] blend_c1;
    logic signed [31:0] blend_c2;
    logic signed [31:0] blend_c3;
  } out_item_t;

  // Cell offsets of one query on both axes.
  typedef struct packed {
    logic [OFF_W-1:0] f1;
    logic [OFF_W-1:0] f2;
  } off_pair_t;

  // Grid memory control for one pipeline slot.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[src/gbi_locate.sv]
// ----------------------------------------------------------------------------
// gbi_locate: coordinate to cell index and offset
// Four register stages: difference, scale multiply, rounding shift, clamp.
// ----------------------------------------------------------------------------
module gbi_locate #(
  parameter int MAX_CELLS = gbi_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic signed [31:0]           x,
  input  logic signed [31:0]           org,
  input  logic        [31:0]           inv,
  input  logic        [8:0]            used,
  output logic [$clog2(MAX_CELLS)-1:0] idx,
  output logic [gbi_pkg::OFF_W-1:0]    off
);

  localparam int IW = $clog2(MAX_CELLS);

  logic [31:0]               mag_r, mag_nxt;
  logic                      neg1_r, neg2_r, neg3_r;
  logic [63:0]               prod_r, prod_nxt;
  logic [40:0]               t_r, t_nxt;
  logic [IW-1:0]             idx_r, idx_nxt;
  logic [gbi_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [32:0]               d;
  logic [64:0]               rsum;

  // Stage 1: exact difference and its magnitude.
  always_comb begin
    d       = {x[31], x} - {org[31], org};
    mag_nxt = d[32] ? 32'(-d) : d[31:0];
  end

  // Stage 2: scale by the reciprocal spacing.
  assign prod_nxt = 64'(mag_r) * 64'(inv);

  // Stage 3: drop 24 fraction bits, rounding the magnitude up when negative.
  always_comb begin
    rsum  = {1'b0, prod_r} + 65'h0_00FF_FFFF;
    t_nxt = neg2_r ? rsum[64:24] : {1'b0, prod_r[63:24]};
  end

  // Stage 4: remove the half-cell bias and clamp to the grid.
  always_comb begin
    logic signed [42:0] ub;
    logic signed [42:0] u;
    logic [25:0]        q;
    logic [25:0]        nm2;
    int                 n;
    ub = {2'b00, t_r};
    u  = neg3_r ? (-ub - 43'sd32768) : (ub - 43'sd32768);
    q  = u[41:16];
    n  = int'(used);
    if (n < 2) n = 2;
    if (n > MAX_CELLS) n = MAX_CELLS;
    nm2 = 26'(n - 2);
    if (u[42]) begin
      idx_nxt = '0;
      off_nxt = '0;
    end else if (q > nm2) begin
      idx_nxt = nm2[IW-1:0];
      off_nxt = gbi_pkg::OFF_ONE;
    end else begin
      idx_nxt = q[IW-1:0];
      off_nxt = {1'b0, u[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg1_r <= d[32];
    prod_r <= prod_nxt;
    neg2_r <= neg1_r;
    t_r    <= t_nxt;
    neg3_r <= neg2_r;
    idx_r  <= idx_nxt;
    off_r  <= off_nxt;
  end

  assign idx = idx_r;
  assign off = off_r;

endmodule

[src/gbi_grid_mem.sv]
// ----------------------------------------------------------------------------
// gbi_grid_mem: four-bank cell store
// Cells are banked by row and column parity, so the four neighbors of a
// query come from four different banks at once. Read data is registered.
// ----------------------------------------------------------------------------
module gbi_grid_mem #(
  parameter int MAX_ROWS   = gbi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = gbi_pkg::MAX_COLS_DEF,
  parameter int COMPONENTS = gbi_pkg::COMPONENTS_DEF
) (
  input  logic                                         clk,
  input  gbi_pkg::mem_ctl_t                            ctl,
  input  logic [7:0]                                   wr_row,
  input  logic [7:0]                                   wr_col,
  input  logic [COMPONENTS-1:0][gbi_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [$clog2(MAX_ROWS)-1:0]                  rd_i,
  input  logic [$clog2(MAX_COLS)-1:0]                  rd_j,
  output logic [3:0][COMPONENTS-1:0][gbi_pkg::SAMPLE_W-1:0] corner
);

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int HALF_R = (MAX_ROWS + 1) / 2;
  localparam int HALF_C = (MAX_COLS + 1) / 2;
  localparam int DEPTH  = HALF_R * HALF_C;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = COMPONENTS * gbi_pkg::SAMPLE_W;

  logic [3:0][AW-1:0] raddr;
  logic [AW-1:0]      waddr;
  logic [1:0]         wbank;
  logic               wr_ok;
  logic [DW-1:0]      rdata_r [4];
  logic               par_i_r, par_j_r;

  // Write address and bank; writes outside storage are dropped.
  always_comb begin
    wbank = {wr_row[0], wr_col[0]};
    waddr = AW'(int'(wr_row >> 1) * HALF_C + int'(wr_col >> 1));
    wr_ok = ctl.wr_en && (int'(wr_row) < MAX_ROWS) && (int'(wr_col) < MAX_COLS);
  end

  // Each bank reads whichever of rows i, i+1 and columns j, j+1 it holds.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [RW-1:0] brow;
      logic [CW-1:0] bcol;
      brow = (rd_i[0] == b[1]) ? rd_i : rd_i + RW'(1);
      bcol = (rd_j[0] == b[0]) ? rd_j : rd_j + CW'(1);
      raddr[b] = AW'(int'(brow >> 1) * HALF_C + int'(bcol >> 1));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_ok && (wbank == 2'(b))) begin
        mem[waddr] <= wr_data;
      end
      if (ctl.rd_en) begin
        rdata_r[b] <= mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      par_i_r <= rd_i[0];
      par_j_r <= rd_j[0];
    end
  end

  // Route banks to corners: (i,j), (i,j+1), (i+1,j), (i+1,j+1).
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      corner[t] = rdata_r[{par_i_r ^ t[1], par_j_r ^ t[0]}];
    end
  end

endmodule

[src/gbi_blend.sv]
// ----------------------------------------------------------------------------
// gbi_blend: bilinear weighting of four corner samples
// Stages: weights, sample products, corner sum, round and saturate.
// ----------------------------------------------------------------------------
module gbi_blend #(
  parameter int COMPONENTS = gbi_pkg::COMPONENTS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  input  gbi_pkg::off_pair_t                                offs,
  input  logic [3:0][COMPONENTS-1:0][gbi_pkg::SAMPLE_W-1:0] corner,
  output logic                                              res_valid,
  output logic [COMPONENTS-1:0][gbi_pkg::SAMPLE_W-1:0]      res_data
);

  logic [3:0]                          vld_r;
  logic [3:0][32:0]                    w_r, w_nxt;
  logic signed [64:0]                  prod_r [4][COMPONENTS];
  logic signed [66:0]                  acc_r [COMPONENTS];
  logic [COMPONENTS-1:0][31:0]         res_r, res_nxt;

  // Corner weights as Q1.32 products of the axis offsets.
  always_comb begin
    logic [16:0] g1, g2;
    g1 = gbi_pkg::OFF_ONE - offs.f1;
    g2 = gbi_pkg::OFF_ONE - offs.f2;
    w_nxt[0] = 33'(g1) * 33'(g2);
    w_nxt[1] = 33'(g1) * 33'(offs.f2);
    w_nxt[2] = 33'(offs.f1) * 33'(g2);
    w_nxt[3] = 33'(offs.f1) * 33'(offs.f2);
  end

  // Round half up and saturate to 32 bits.
  always_comb begin
    for (int c = 0; c < COMPONENTS; c++) begin
      logic signed [66:0] rnd;
      logic signed [34:0] sh;
      rnd = acc_r[c] + 67'sd2147483648;
      sh  = rnd[66:32];
      if (sh > 35'sd2147483647) begin
        res_nxt[c] = 32'h7FFF_FFFF;
      end else if (sh < -35'sd2147483648) begin
        res_nxt[c] = 32'h8000_0000;
      end else begin
        res_nxt[c] = sh[31:0];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    for (int t = 0; t < 4; t++) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        prod_r[t][c] <= 65'($signed(corner[t][c]) * $signed({1'b0, w_r[t]}));
      end
    end
    for (int c = 0; c < COMPONENTS; c++) begin
      acc_r[c] <= 67'(prod_r[0][c]) + 67'(prod_r[1][c])
                + 67'(prod_r[2][c]) + 67'(prod_r[3][c]);
    end
    res_r <= res_nxt;
  end

  // Valid bits follow the data through the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  assign res_valid = vld_r[3];
  assign res_data  = res_r;

endmodule

[src/grid_bilinear_interpolator.sv]
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator: clamped bilinear lookup on a banked cell grid
// Results pass the locate, grid read and blend registers before out_valid rises.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset clears the valid bits and the configuration registers; the grid keeps
// its contents.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator #(
  parameter int MAX_ROWS   = gbi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = gbi_pkg::MAX_COLS_DEF,
  parameter int COMPONENTS = gbi_pkg::COMPONENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gbi_pkg::in_item_t in_item,
  output logic              out_valid,
  output gbi_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic [31:0]               origin_x1_r, origin_x2_r;
  logic [31:0]               inv_x1_r, inv_x2_r;
  logic [8:0]                used_x1_r, used_x2_r;
  logic [4:0]                val_r;
  gbi_pkg::in_item_t         itm_r [5];
  logic [RW-1:0]             loc_i;
  logic [CW-1:0]             loc_j;
  gbi_pkg::off_pair_t        offs;
  gbi_pkg::mem_ctl_t         mctl;
  logic [3:0][31:0]          samp4;
  logic [COMPONENTS-1:0][31:0] wdata;
  logic [3:0][COMPONENTS-1:0][31:0] corner;
  logic                      res_valid;
  logic [COMPONENTS-1:0][31:0] res_data;
  logic [3:0][31:0]          res_all;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x1_r <= '0;
      origin_x2_r <= '0;
      inv_x1_r    <= gbi_pkg::INV_SPACING_RST;
      inv_x2_r    <= gbi_pkg::INV_SPACING_RST;
      used_x1_r   <= gbi_pkg::CELLS_USED_RST;
      used_x2_r   <= gbi_pkg::CELLS_USED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (gbi_pkg::cfg_reg_t'(cfg_index))
        gbi_pkg::CFG_ORIGIN_X1:      origin_x1_r <= cfg_data;
        gbi_pkg::CFG_ORIGIN_X2:      origin_x2_r <= cfg_data;
        gbi_pkg::CFG_INV_SPACING_X1: inv_x1_r    <= cfg_data;
        gbi_pkg::CFG_INV_SPACING_X2: inv_x2_r    <= cfg_data;
        gbi_pkg::CFG_CELLS_USED_X1:  used_x1_r   <= cfg_data[8:0];
        gbi_pkg::CFG_CELLS_USED_X2:  used_x2_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Item pipeline, aligned with the locate stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= {val_r[3:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    itm_r[0] <= in_item;
    for (int s = 1; s < 5; s++) begin
      itm_r[s] <= itm_r[s-1];
    end
  end

  // Locate both axes.
  gbi_locate #(.MAX_CELLS(MAX_ROWS)) u_loc_x1 (
    .clk  (clk),
    .x    (itm_r[0].point_x1),
    .org  (origin_x1_r),
    .inv  (inv_x1_r),
    .used (used_x1_r),
    .idx  (loc_i),
    .off  (offs.f1)
  );

  gbi_locate #(.MAX_CELLS(MAX_COLS)) u_loc_x2 (
    .clk  (clk),
    .x    (itm_r[0].point_x2),
    .org  (origin_x2_r),
    .inv  (inv_x2_r),
    .used (used_x2_r),
    .idx  (loc_j),
    .off  (offs.f2)
  );

  // Writes and reads meet the grid at the same stage, so order is kept.
  assign mctl.wr_en = val_r[4] && (itm_r[4].mode == gbi_pkg::MODE_WRITE);
  assign mctl.rd_en = val_r[4] && (itm_r[4].mode == gbi_pkg::MODE_QUERY);

  assign samp4 = {itm_r[4].sample_c3, itm_r[4].sample_c2,
                  itm_r[4].sample_c1, itm_r[4].sample_c0};

  for (genvar c = 0; c < COMPONENTS; c++) begin : g_wdata
    assign wdata[c] = samp4[c];
  end

  gbi_grid_mem #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COMPONENTS (COMPONENTS)
  ) u_mem (
    .clk     (clk),
    .ctl     (mctl),
    .wr_row  (itm_r[4].cell_row),
    .wr_col  (itm_r[4].cell_col),
    .wr_data (wdata),
    .rd_i    (loc_i),
    .rd_j    (loc_j),
    .corner  (corner)
  );

  gbi_blend #(.COMPONENTS(COMPONENTS)) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mctl.rd_en),
    .offs      (offs),
    .corner    (corner),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Components that are not stored read as zero.
  for (genvar c = 0; c < 4; c++) begin : g_res
    if (c < COMPONENTS) begin : g_used
      assign res_all[c] = res_data[c];
    end else begin : g_unused
      assign res_all[c] = '0;
    end
  end

  assign out_valid         = res_valid;
  assign out_item.blend_c0 = res_all[0];
  assign out_item.blend_c1 = res_all[1];
  assign out_item.blend_c2 = res_all[2];
  assign out_item.blend_c3 = res_all[3];

`ifndef ASSERT_OFF
  // A result strobe always traces back to an earlier accepted query.
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_item.mode == gbi_pkg::MODE_QUERY, 9))
    else $error("result strobe without a matching query");

  // Cell offsets never exceed one whole cell.
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    mctl.rd_en |-> (offs.f1 <= gbi_pkg::OFF_ONE && offs.f2 <= gbi_pkg::OFF_ONE))
    else $error("cell offset out of range");

  // Reset leaves no result strobe behind.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
`endif

endmodule

[tb/blend_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blend_checker: result predictor and scoreboard of the grid interpolator
// Follows the item, result and register channels, keeps its own copy of the
// grid and the registers, predicts every query and compares each result.
// ----------------------------------------------------------------------------
module blend_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  gbi_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  gbi_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 pending,
  output int                 fail_count
);

  // Shadow registers, as after reset.
  logic [31:0] origin_x1 = '0;
  logic [31:0] origin_x2 = '0;
  logic [31:0] inv_x1    = gbi_pkg::INV_SPACING_RST;
  logic [31:0] inv_x2    = gbi_pkg::INV_SPACING_RST;
  logic [8:0]  used_x1   = gbi_pkg::CELLS_USED_RST;
  logic [8:0]  used_x2   = gbi_pkg::CELLS_USED_RST;

  // Grid copy, keyed by row * MAX_COLS + col, components packed c3..c0.
  logic [3:0][31:0]   grid_cells [int];
  gbi_pkg::out_item_t blend_q [$];
  int                 errors = 0;

  // Cell index and Q1.16 offset of one coordinate, clamped to the grid.
  function automatic void locate(input logic [31:0] x, input logic [31:0] org,
                                 input logic [31:0] inv, input logic [8:0] used,
                                 input int maxc, output int idx, output int off);
    longint      d;
    logic [63:0] mag;
    logic [63:0] prod;
    longint      u;
    int          n;
    d    = longint'($signed(x)) - longint'($signed(org));
    mag  = (d < 0) ? -d : d;
    prod = mag * inv;
    n    = used;
    if (n < 2) n = 2;
    if (n > maxc) n = maxc;
    if (d < 0) u = -longint'((prod + 64'hFFFFFF) >> 24);
    else u = longint'(prod >> 24);
    u = u - 32768;
    if (u < 0) begin
      idx = 0;
      off = 0;
    end else if ((u >>> 16) > n - 2) begin
      idx = n - 2;
      off = 65536;
    end else begin
      idx = int'(u >>> 16);
      off = int'(u & 64'hFFFF);
    end
  endfunction

  // Lower corner cell of a query under the current registers.
  function automatic void cell_base(input gbi_pkg::in_item_t q, output int row,
                                    output int col);
    int f;
    locate(q.point_x1, origin_x1, inv_x1, used_x1, gbi_pkg::MAX_ROWS_DEF, row, f);
    locate(q.point_x2, origin_x2, inv_x2, used_x2, gbi_pkg::MAX_COLS_DEF, col, f);
  endfunction

  // Bilinear blend of the four neighbor cells, rounded half up and saturated.
  function automatic gbi_pkg::out_item_t blend(input gbi_pkg::in_item_t q);
    int                 i, j, f1, f2, t, c;
    longint             w [4];
    int                 addr [4];
    logic [3:0][31:0]   s;
    longint             sv;
    logic signed [71:0] acc;
    logic [3:0][31:0]   res;
    locate(q.point_x1, origin_x1, inv_x1, used_x1, gbi_pkg::MAX_ROWS_DEF, i, f1);
    locate(q.point_x2, origin_x2, inv_x2, used_x2, gbi_pkg::MAX_COLS_DEF, j, f2);
    w[0] = longint'(65536 - f1) * longint'(65536 - f2);
    w[1] = longint'(65536 - f1) * longint'(f2);
    w[2] = longint'(f1) * longint'(65536 - f2);
    w[3] = longint'(f1) * longint'(f2);
    addr[0] = i * gbi_pkg::MAX_COLS_DEF + j;
    addr[1] = addr[0] + 1;
    addr[2] = addr[0] + gbi_pkg::MAX_COLS_DEF;
    addr[3] = addr[2] + 1;
    for (c = 0; c < 4; c++) begin
      acc = '0;
      for (t = 0; t < 4; t++) begin
        s   = grid_cells.exists(addr[t]) ? grid_cells[addr[t]] : '0;
        sv  = longint'($signed(s[c]));
        acc = acc + sv * w[t];
      end
      acc = (acc + 72'sd2147483648) >>> 32;
      if (acc > 72'sd2147483647) acc = 72'sd2147483647;
      if (acc < -72'sd2147483648) acc = -72'sd2147483648;
      res[c] = acc[31:0];
    end
    blend.blend_c0 = res[0];
    blend.blend_c1 = res[1];
    blend.blend_c2 = res[2];
    blend.blend_c3 = res[3];
  endfunction

  // Report one field that differs from its prediction.
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    gbi_pkg::out_item_t want;
    if (!rst_n) begin
      origin_x1 = '0;
      origin_x2 = '0;
      inv_x1    = gbi_pkg::INV_SPACING_RST;
      inv_x2    = gbi_pkg::INV_SPACING_RST;
      used_x1   = gbi_pkg::CELLS_USED_RST;
      used_x2   = gbi_pkg::CELLS_USED_RST;
      blend_q.delete();
    end else begin
      // Results leave in the order their queries came in.
      if (out_valid) begin
        if (blend_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual %h", $time, out_item);
        end else begin
          want = blend_q.pop_front();
          check_field("blend_c0", want.blend_c0, out_item.blend_c0);
          check_field("blend_c1", want.blend_c1, out_item.blend_c1);
          check_field("blend_c2", want.blend_c2, out_item.blend_c2);
          check_field("blend_c3", want.blend_c3, out_item.blend_c3);
        end
      end
      // Accepted item: store a cell or predict a query.
      if (start && !busy) begin
        if (in_item.mode == gbi_pkg::MODE_WRITE) begin
          if (in_item.cell_row < gbi_pkg::MAX_ROWS_DEF &&
              in_item.cell_col < gbi_pkg::MAX_COLS_DEF)
            grid_cells[in_item.cell_row * gbi_pkg::MAX_COLS_DEF + in_item.cell_col] =
              {in_item.sample_c3, in_item.sample_c2, in_item.sample_c1,
               in_item.sample_c0};
        end else begin
          blend_q.push_back(blend(in_item));
        end
      end
      // Register write; spare indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gbi_pkg::CFG_ORIGIN_X1:      origin_x1 = cfg_data;
          gbi_pkg::CFG_ORIGIN_X2:      origin_x2 = cfg_data;
          gbi_pkg::CFG_INV_SPACING_X1: inv_x1    = cfg_data;
          gbi_pkg::CFG_INV_SPACING_X2: inv_x2    = cfg_data;
          gbi_pkg::CFG_CELLS_USED_X1:  used_x1   = cfg_data[8:0];
          gbi_pkg::CFG_CELLS_USED_X2:  used_x2   = cfg_data[8:0];
          default: ;
        endcase
      end
    end
    pending    <= blend_q.size();
    fail_count <= errors;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the grid bilinear interpolator
// Loads cells and sends queries under several register settings, with random
// gaps, and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RUN_LIMIT    = 1500000;
  localparam int          SETTLE       = 12;
  localparam int          PHASE_ITEMS  = 280;
  localparam logic [2:0]  CFG_SPARE_LO = 3'd6;
  localparam logic [2:0]  CFG_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  gbi_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  gbi_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 pending;
  int                 fail_count;
  int                 cycles = 0;
  int                 n_items = 0;
  bit                 idle_on = 1'b1;
  bit                 written [int];

  always #5 clk = ~clk;

  grid_bilinear_interpolator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  blend_checker i_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("grid_bilinear_interpolator test failed");
      $finish;
    end
  end

  // Gap before an item: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // An item with every field random.
  function automatic gbi_pkg::in_item_t rand_item();
    logic [223:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r[$bits(gbi_pkg::in_item_t)-1:0];
  endfunction

  // Hand one item over and hold it until it is taken.
  task automatic put(input gbi_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    n_items++;
  endtask

  // Wait until every result has come and the pipeline has drained.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_cell(input int row, input int col, input logic [31:0] s0,
                            input logic [31:0] s1, input logic [31:0] s2,
                            input logic [31:0] s3);
    gbi_pkg::in_item_t it;
    it = rand_item();
    it.mode      = gbi_pkg::MODE_WRITE;
    it.cell_row  = row[7:0];
    it.cell_col  = col[7:0];
    it.sample_c0 = s0;
    it.sample_c1 = s1;
    it.sample_c2 = s2;
    it.sample_c3 = s3;
    written[row * gbi_pkg::MAX_COLS_DEF + col] = 1'b1;
    put(it);
  endtask

  // Query a point; any cell it touches that holds nothing yet is loaded first.
  task automatic query(input logic [31:0] x1, input logic [31:0] x2);
    gbi_pkg::in_item_t it;
    int row, col, dr, dc;
    it = rand_item();
    it.mode     = gbi_pkg::MODE_QUERY;
    it.point_x1 = x1;
    it.point_x2 = x2;
    i_chk.cell_base(it, row, col);
    for (dr = 0; dr < 2; dr++)
      for (dc = 0; dc < 2; dc++)
        if (!written.exists((row + dr) * gbi_pkg::MAX_COLS_DEF + col + dc))
          write_cell(row + dr, col + dc, $urandom, $urandom, $urandom, $urandom);
    put(it);
  endtask

  // A coordinate that mostly lands on or just around the grid in use.
  function automatic logic [31:0] near(input logic [31:0] org, input logic [31:0] inv,
                                       input logic [8:0] used);
    longint k;
    longint d;
    if (inv == 0 || $urandom_range(0, 7) == 0) return $urandom;
    k = longint'($urandom_range(0, (int'(used) + 2) * 1024)) - 1024;
    d = k * (longint'(1) << 30) / longint'(inv);
    return org + d[31:0];
  endfunction

  // Register settings of one phase.
  task automatic setup_phase(input int p);
    case (p)
      1: begin
        set_reg(gbi_pkg::CFG_ORIGIN_X1, '0);
        set_reg(gbi_pkg::CFG_ORIGIN_X2, '0);
        set_reg(gbi_pkg::CFG_INV_SPACING_X1, 32'd65536);
        set_reg(gbi_pkg::CFG_INV_SPACING_X2, 32'd65536);
        set_reg(gbi_pkg::CFG_CELLS_USED_X1, 32'd4);
        set_reg(gbi_pkg::CFG_CELLS_USED_X2, 32'd3);
      end
      2: begin
        set_reg(gbi_pkg::CFG_ORIGIN_X1, 32'h8000_0000);
        set_reg(gbi_pkg::CFG_ORIGIN_X2, 32'h7FFF_FFFF);
        set_reg(gbi_pkg::CFG_INV_SPACING_X1, 32'hFFFF_FFFF);
        set_reg(gbi_pkg::CFG_INV_SPACING_X2, 32'd0);
        set_reg(gbi_pkg::CFG_CELLS_USED_X1, 32'hFFFF_FE00);
        set_reg(gbi_pkg::CFG_CELLS_USED_X2, 32'd1);
        set_reg(CFG_SPARE_LO, $urandom);
      end
      3: begin
        set_reg(gbi_pkg::CFG_ORIGIN_X1, $urandom);
        set_reg(gbi_pkg::CFG_ORIGIN_X2, $urandom);
        set_reg(gbi_pkg::CFG_INV_SPACING_X1, 32'h0010_0000);
        set_reg(gbi_pkg::CFG_INV_SPACING_X2, 32'h0000_4000);
        set_reg(gbi_pkg::CFG_CELLS_USED_X1, 32'd511);
        set_reg(gbi_pkg::CFG_CELLS_USED_X2, 32'd256);
        set_reg(CFG_SPARE_HI, $urandom);
      end
      default: begin
        set_reg(gbi_pkg::CFG_ORIGIN_X1, $urandom);
        set_reg(gbi_pkg::CFG_ORIGIN_X2, $urandom);
        set_reg(gbi_pkg::CFG_INV_SPACING_X1, $urandom_range(32'h1000, 32'h0040_0000));
        set_reg(gbi_pkg::CFG_INV_SPACING_X2, $urandom_range(32'h1000, 32'h0040_0000));
        set_reg(gbi_pkg::CFG_CELLS_USED_X1, $urandom_range(2, 20));
        set_reg(gbi_pkg::CFG_CELLS_USED_X2, $urandom_range(2, 20));
      end
    endcase
  endtask

  initial begin
    int p, base;
    bit mid_done;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme samples, exact cell hits, fractions, both clamps.
    write_cell(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    write_cell(0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0001);
    write_cell(1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h8000_0001);
    write_cell(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'h7FFF_FFFE);
    query(32'd0, 32'd0);
    query(32'h0080_0000, 32'h0080_0000);
    query(32'h00C0_0000, 32'h00C0_0000);
    query(32'h0100_0000, 32'h00A0_0001);
    query(32'h0180_0000, 32'h0180_0000);
    query(32'h8000_0000, 32'h8000_0000);
    query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query(32'h7FFF_FFFF, 32'h8000_0000);
    query(32'h8000_0000, 32'h00C0_0000);
    write_cell(255, 255, $urandom, $urandom, $urandom, $urandom);
    query(32'h7F80_0000, 32'h7F40_0000);
    query(32'h0580_0000, 32'h7FFF_FFFF);

    // Random phases under different register settings, each with a fixed
    // budget of items that includes the cell loads a query brings along.
    base = n_items;
    for (p = 0; p < 5; p++) begin
      settle();
      if (p > 0) setup_phase(p);
      idle_on  = (p != 2);
      mid_done = 1'b0;
      while (n_items < base + (p + 1) * PHASE_ITEMS) begin
        if (!mid_done && n_items >= base + p * PHASE_ITEMS + PHASE_ITEMS / 2) begin
          settle();
          mid_done = 1'b1;
        end
        if ($urandom_range(0, 9) < 2)
          write_cell($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom, $urandom, $urandom, $urandom);
        else
          query(near(i_chk.origin_x1, i_chk.inv_x1, i_chk.used_x1),
                near(i_chk.origin_x2, i_chk.inv_x2, i_chk.used_x2));
      end
    end

    settle();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("grid_bilinear_interpolator test passed");
    end else begin
      $display("grid_bilinear_interpolator test failed");
    end
    $finish;
  end

endmodule
